// File: design/mcps_pkg.sv
// Shared constants and types for the min-cost permutation search block.
`default_nettype none

package mcps_pkg;

    localparam int MAX_K_DEF  = 8;
    localparam int COST_W     = 32;
    localparam int SUM_W      = 35;
    localparam int KREG_W     = 4;
    localparam int FIELD_IDX_W = 3;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 35;
    localparam int OUT_TDATA_W = 48;

    localparam logic [CFG_ADDR_W-1:0] REG_NUM_CLUSTERS = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_COST_CEILING = 1'd1;

    localparam logic [KREG_W-1:0]       K_RESET    = 4'd3;
    localparam logic signed [SUM_W-1:0] CEIL_RESET = 35'sd6553600;

    // Controls from the sequencer to the cost store and accumulator.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic acc_clr;
    } acc_ctrl_t;

endpackage

`default_nettype wire

// File: design/mcps_next_perm.sv
// Next lexicographic permutation of the first K positions.
`default_nettype none

module mcps_next_perm #(
    parameter int MAX_K = 8,
    parameter int IDX_W = $clog2(MAX_K),
    parameter int KW    = $clog2(MAX_K + 1)
) (
    input  wire logic [MAX_K-1:0][IDX_W-1:0] perm_i,
    input  wire logic [KW-1:0]               k_i,
    output logic      [MAX_K-1:0][IDX_W-1:0] perm_o,
    output logic                             has_next_o
);

    always_comb begin
        logic [IDX_W-1:0]             pivot;
        logic [IDX_W-1:0]             pivot_m1;
        logic [IDX_W-1:0]             swp;
        logic [IDX_W-1:0]             pv;
        logic [KW:0]                  src;
        logic [MAX_K-1:0][IDX_W-1:0]  q;

        // Pivot: last position i with p[i-1] < p[i].
        pivot = '0;
        for (int i = 1; i < MAX_K; i++) begin
            if (KW'(i) < k_i && perm_i[i-1] < perm_i[i]) begin
                pivot = IDX_W'(i);
            end
        end
        has_next_o = (pivot != '0);
        pivot_m1   = pivot - 1'b1;
        pv         = perm_i[pivot_m1];

        // Successor: last position at or after the pivot holding a larger value.
        swp = pivot;
        for (int j = 1; j < MAX_K; j++) begin
            if (KW'(j) < k_i && IDX_W'(j) >= pivot && perm_i[j] > pv) begin
                swp = IDX_W'(j);
            end
        end

        q           = perm_i;
        q[pivot_m1] = perm_i[swp];
        q[swp]      = pv;

        // Reverse the tail from the pivot to K-1.
        perm_o = q;
        for (int x = 0; x < MAX_K; x++) begin
            src = (KW+1)'(k_i) + (KW+1)'(pivot) - (KW+1)'(x) - 1'b1;
            if (IDX_W'(x) >= pivot && KW'(x) < k_i) begin
                perm_o[x] = q[src[IDX_W-1:0]];
            end
        end
    end

endmodule

`default_nettype wire

// File: design/mcps_cost_acc.sv
// Cost matrix store with registered read and the shared Q16.16 accumulator.
`default_nettype none

module mcps_cost_acc #(
    parameter int MAX_K  = 8,
    parameter int ADDR_W = $clog2(MAX_K * MAX_K)
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire mcps_pkg::acc_ctrl_t             ctrl_i,
    input  wire logic [ADDR_W-1:0]               wr_addr_i,
    input  wire logic [mcps_pkg::COST_W-1:0]     wr_data_i,
    input  wire logic [ADDR_W-1:0]               rd_addr_i,
    output logic                                 rd_valid_o,
    output logic signed [mcps_pkg::SUM_W-1:0]    sum_o
);
    import mcps_pkg::*;

    localparam int DEPTH = MAX_K * MAX_K;

    logic [COST_W-1:0]       mem [DEPTH];
    logic [COST_W-1:0]       rdata_reg;
    logic                    rd_valid_reg;
    logic signed [SUM_W-1:0] acc_reg;
    logic signed [SUM_W-1:0] acc_next;
    logic signed [SUM_W-1:0] entry;

    always_ff @(posedge aclk) begin
        if (ctrl_i.wr_en) begin
            mem[wr_addr_i] <= wr_data_i;
        end
        if (ctrl_i.rd_en) begin
            rdata_reg <= mem[rd_addr_i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= ctrl_i.rd_en;
        end
    end

    assign entry    = rd_valid_reg ? SUM_W'(signed'(rdata_reg)) : '0;
    assign acc_next = acc_reg + entry;

    always_ff @(posedge aclk) begin
        if (ctrl_i.acc_clr) begin
            acc_reg <= '0;
        end else begin
            acc_reg <= acc_next;
        end
    end

    assign rd_valid_o = rd_valid_reg;
    assign sum_o      = acc_next;

endmodule

`default_nettype wire

// File: design/min_cost_permutation_search.sv
// Top level: brute-force minimum-cost assignment search over a K-by-K matrix.
//
// Usage:
//  - Set K with register num_clusters (index 0, clamped to 2..MAX_K) and the
//    starting best sum with cost_ceiling (index 1, signed Q16.16) through the
//    cfg_* write port, only while the block is idle. Writing K restarts a load.
//  - Stream the K*K cost entries row-major on s_*; s_tready is high only while
//    loading, one entry per cycle.
//  - After the last entry the block walks every permutation in lexicographic
//    order. Each permutation takes K reads of the cost store through one
//    shared adder, then one compare and permutation step.
//  - It then emits K results on m_*, rows 0..K-1, m_tlast on row K-1,
//    m_tuser = found. A stalled receiver holds the current row; the next load
//    starts after the last row is taken.
//  - Reset (aresetn low, synchronous) returns to loading with K = 3 and a
//    ceiling of 100.0; store contents are not cleared.
`default_nettype none

module min_cost_permutation_search #(
    parameter int MAX_K = mcps_pkg::MAX_K_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // tdata: cost[31:0]
    input  wire logic [mcps_pkg::COST_W-1:0]         s_tdata,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // tdata: row[2:0], assigned_col[5:3], best_cost[40:6], zero fill [47:41]
    output logic [mcps_pkg::OUT_TDATA_W-1:0]         m_tdata,
    // tuser: found[0]
    output logic                                     m_tuser,
    output logic                                     m_tlast,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    input  wire logic                                cfg_wr_en,
    input  wire logic [mcps_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [mcps_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);
    import mcps_pkg::*;

    localparam int IDX_W  = $clog2(MAX_K);
    localparam int KW     = $clog2(MAX_K + 1);
    localparam int ADDR_W = $clog2(MAX_K * MAX_K);

    typedef enum logic [4:0] {
        ST_LOAD = 5'b00001,
        ST_INIT = 5'b00010,
        ST_SUM  = 5'b00100,
        ST_CMP  = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    typedef logic [MAX_K-1:0][IDX_W-1:0] perm_t;

    state_t                  state_reg, state_next;
    logic [KREG_W-1:0]       num_clusters_reg, num_clusters_next;
    logic signed [SUM_W-1:0] ceiling_reg, ceiling_next;
    logic [ADDR_W-1:0]       load_cnt_reg, load_cnt_next;
    logic [IDX_W-1:0]        row_reg, row_next;
    logic [ADDR_W-1:0]       base_reg, base_next;
    perm_t                   perm_reg, perm_next;
    perm_t                   best_perm_reg, best_perm_next;
    logic signed [SUM_W-1:0] best_sum_reg, best_sum_next;
    logic                    found_reg, found_next;

    logic [KW-1:0]           k_eff;
    logic [2*KW-1:0]         k_sq;
    logic [ADDR_W-1:0]       total_m1;
    logic [IDX_W-1:0]        k_m1;
    perm_t                   perm_step;
    perm_t                   perm_ident;
    logic                    has_next;
    acc_ctrl_t               acc_ctrl;
    logic [ADDR_W-1:0]       rd_addr;
    logic                    rd_valid;
    logic signed [SUM_W-1:0] perm_sum;
    logic                    in_req;

    // Clamp K into the supported range.
    always_comb begin
        if (num_clusters_reg < KREG_W'(2)) begin
            k_eff = KW'(2);
        end else if (num_clusters_reg > KREG_W'(MAX_K)) begin
            k_eff = KW'(MAX_K);
        end else begin
            k_eff = KW'(num_clusters_reg);
        end
    end

    assign k_sq     = (2*KW)'(k_eff) * (2*KW)'(k_eff);
    assign total_m1 = ADDR_W'(k_sq - 1'b1);
    assign k_m1     = IDX_W'(k_eff - 1'b1);

    always_comb begin
        for (int r = 0; r < MAX_K; r++) begin
            perm_ident[r] = IDX_W'(r);
        end
    end

    assign in_req  = s_tvalid && s_tready;
    assign rd_addr = base_reg + ADDR_W'(perm_reg[row_reg]);

    mcps_next_perm #(
        .MAX_K (MAX_K),
        .IDX_W (IDX_W),
        .KW    (KW)
    ) u_next_perm (
        .perm_i     (perm_reg),
        .k_i        (k_eff),
        .perm_o     (perm_step),
        .has_next_o (has_next)
    );

    mcps_cost_acc #(
        .MAX_K  (MAX_K),
        .ADDR_W (ADDR_W)
    ) u_cost_acc (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl_i     (acc_ctrl),
        .wr_addr_i  (load_cnt_reg),
        .wr_data_i  (s_tdata),
        .rd_addr_i  (rd_addr),
        .rd_valid_o (rd_valid),
        .sum_o      (perm_sum)
    );

    // Sequencer: load, initialize, sum K entries, compare and step, emit rows.
    always_comb begin
        state_next        = state_reg;
        num_clusters_next = num_clusters_reg;
        ceiling_next      = ceiling_reg;
        load_cnt_next     = load_cnt_reg;
        row_next          = row_reg;
        base_next         = base_reg;
        perm_next         = perm_reg;
        best_perm_next    = best_perm_reg;
        best_sum_next     = best_sum_reg;
        found_next        = found_reg;
        acc_ctrl          = '0;

        case (state_reg)
            ST_LOAD: begin
                if (in_req) begin
                    acc_ctrl.wr_en = 1'b1;
                    if (load_cnt_reg == total_m1) begin
                        load_cnt_next = '0;
                        state_next    = ST_INIT;
                    end else begin
                        load_cnt_next = load_cnt_reg + 1'b1;
                    end
                end
            end
            ST_INIT: begin
                // Seed the search: identity first, ceiling as the bar to beat.
                perm_next        = perm_ident;
                best_perm_next   = '0;
                best_sum_next    = ceiling_reg;
                found_next       = 1'b0;
                acc_ctrl.acc_clr = 1'b1;
                row_next         = '0;
                base_next        = '0;
                state_next       = ST_SUM;
            end
            ST_SUM: begin
                // Issue one read per row; the adder folds in the previous one.
                acc_ctrl.rd_en = 1'b1;
                if (row_reg == k_m1) begin
                    row_next   = '0;
                    base_next  = '0;
                    state_next = ST_CMP;
                end else begin
                    row_next  = row_reg + 1'b1;
                    base_next = base_reg + ADDR_W'(k_eff);
                end
            end
            ST_CMP: begin
                // Strictly below keeps the earliest permutation on ties.
                if (perm_sum < best_sum_reg) begin
                    best_sum_next  = perm_sum;
                    best_perm_next = perm_reg;
                    found_next     = 1'b1;
                end
                acc_ctrl.acc_clr = 1'b1;
                if (has_next) begin
                    perm_next  = perm_step;
                    state_next = ST_SUM;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                // Hold the current row until the receiver takes it.
                if (m_tready) begin
                    if (row_reg == k_m1) begin
                        row_next   = '0;
                        state_next = ST_LOAD;
                    end else begin
                        row_next = row_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase

        // Register writes; a new K restarts the load.
        if (cfg_wr_en) begin
            case (cfg_addr)
                REG_NUM_CLUSTERS: begin
                    num_clusters_next = cfg_wr_data[KREG_W-1:0];
                    load_cnt_next     = '0;
                end
                REG_COST_CEILING: begin
                    ceiling_next = signed'(cfg_wr_data[SUM_W-1:0]);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_LOAD;
            num_clusters_reg <= K_RESET;
            ceiling_reg      <= CEIL_RESET;
            load_cnt_reg     <= '0;
            row_reg          <= '0;
            base_reg         <= '0;
            perm_reg         <= perm_ident;
            best_perm_reg    <= '0;
            best_sum_reg     <= '0;
            found_reg        <= 1'b0;
        end else begin
            state_reg        <= state_next;
            num_clusters_reg <= num_clusters_next;
            ceiling_reg      <= ceiling_next;
            load_cnt_reg     <= load_cnt_next;
            row_reg          <= row_next;
            base_reg         <= base_next;
            perm_reg         <= perm_next;
            best_perm_reg    <= best_perm_next;
            best_sum_reg     <= best_sum_next;
            found_reg        <= found_next;
        end
    end

    assign s_tready = (state_reg == ST_LOAD);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tlast  = (row_reg == k_m1);
    assign m_tuser  = found_reg;
    assign m_tdata  = {
        {(OUT_TDATA_W - SUM_W - 2*FIELD_IDX_W){1'b0}},
        best_sum_reg,
        FIELD_IDX_W'(best_perm_reg[row_reg]),
        FIELD_IDX_W'(row_reg)
    };

    // Loading and result delivery never overlap.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input and output channels active together");

    // The compare step always sees the last row's read data.
    a_cmp_has_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CMP) |-> rd_valid)
        else $error("compare without final cost read");

    // The final row taken returns the block to loading.
    a_last_returns: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> s_tready)
        else $error("block did not return to loading after last row");

    // Reported rows stay inside the matrix.
    a_row_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (row_reg <= k_m1))
        else $error("result row beyond K-1");

endmodule

`default_nettype wire
